// ----- design/rgbd_pkg.sv -----
package rgbd_pkg;

  localparam int MAX_LEVEL    = 255;
  localparam int GAMMA_TENTHS = 22;
  localparam int NUM_CHAN     = 3;
  localparam int K_MAX        = 256;

  // command codes
  localparam logic [2:0] CMD_INC  = 3'd0;
  localparam logic [2:0] CMD_DEC  = 3'd1;
  localparam logic [2:0] CMD_NEXT = 3'd2;
  localparam logic [2:0] CMD_PREV = 3'd3;
  localparam logic [2:0] CMD_OFF  = 3'd4;
  localparam logic [2:0] CMD_TICK = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_LEVEL = 2'd0;
  localparam logic [1:0] CFG_SMOOTHING = 2'd1;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;

  typedef logic [255:0][7:0] lut_t;

  localparam int BIG_W = 384;

  function automatic int gamma_exp();
    int g;
    g = GAMMA_TENTHS;
    if (g < 10) g = 10;
    if (g > 30) g = 30;
    return g;
  endfunction

  // largest y with ((2y-1)/510)^10 <= (i/255)^g, exact integer compare
  function automatic logic [7:0] gamma_entry(int i);
    logic [BIG_W-1:0] p255;
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] lhs;
    int g;
    int lo;
    int hi;
    int mid;
    g = gamma_exp();
    p255 = BIG_W'(1);
    for (int j = 0; j < g; j++) p255 = p255 * BIG_W'(255);
    rhs = BIG_W'(1);
    for (int j = 0; j < 10; j++) rhs = rhs * BIG_W'(510);
    for (int j = 0; j < g; j++) rhs = rhs * BIG_W'(i);
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      lhs = p255;
      for (int j = 0; j < 10; j++) lhs = lhs * BIG_W'(2 * mid - 1);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[7:0];
  endfunction

  function automatic lut_t build_gamma();
    lut_t t;
    for (int i = 0; i < 256; i++) t[i] = gamma_entry(i);
    return t;
  endfunction

  // level scaled to 0..255
  function automatic lut_t build_scale();
    lut_t t;
    int v;
    for (int i = 0; i < 256; i++) begin
      v = (i * 255) / MAX_LEVEL;
      if (v > 255) v = 255;
      t[i] = v[7:0];
    end
    return t;
  endfunction

  localparam lut_t GAMMA_ROM = build_gamma();
  localparam lut_t SCALE_ROM = build_scale();

endpackage

// ----- design/rgbd_chan.sv -----
module rgbd_chan (
  input  logic       clk,
  input  logic       rst,
  input  logic       tick,
  input  logic [8:0] k,
  input  logic [7:0] target,
  output logic [7:0] duty
);

  logic        [15:0] smoothed;
  logic signed [17:0] diff;
  logic signed [9:0]  k_s;
  logic signed [27:0] prod;
  logic signed [19:0] q;
  logic signed [20:0] s_sum;
  logic        [15:0] smoothed_next;
  logic        [16:0] rounded;
  logic        [7:0]  idx;

  assign diff = $signed({2'b00, target, 8'h00}) - $signed({2'b00, smoothed});
  assign k_s  = $signed({1'b0, k});
  assign prod = diff * k_s;
  // arithmetic shift floors toward minus infinity
  assign q    = prod[27:8];
  assign s_sum = $signed({5'b00000, smoothed}) + $signed({q[19], q});

  always_comb begin
    if (s_sum < 0) begin
      smoothed_next = 16'h0000;
    end else if (s_sum > 21'sd65535) begin
      smoothed_next = 16'hFFFF;
    end else begin
      smoothed_next = s_sum[15:0];
    end
  end

  assign rounded = {1'b0, smoothed_next} + 17'd128;
  assign idx     = rounded[16] ? 8'hFF : rounded[15:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
      duty     <= '0;
    end else if (tick) begin
      smoothed <= smoothed_next;
      duty     <= rgbd_pkg::GAMMA_ROM[idx];
    end
  end

endmodule

// ----- design/rgb_led_dimmer_smooth_gamma_core.sv -----
// RGB LED dimmer with exponential smoothing and gamma correction.
// Slave side (s_tvalid/s_tready/s_tdata) takes one command word: step the
// selected channel up or down, select the next or previous channel, clear all
// levels, or tick. A tick scales each level to 0..255, runs it through a Q8.8
// first-order smoother and maps the rounded value through a gamma table.
// Master side returns one word per command: selected channel, the three PWM
// duties from the last tick, and the selected channel's raw level.
// The cfg channel writes min_level (index 0) and smoothing_q8 (index 1); it
// is always ready and is meant to be used only while the block is idle.
// Two register stages (input register, then state and result update); m_tvalid
// rises when the command leaves the input register, which waits while the result is held.
// Throughput: one word per cycle while the receiver keeps m_tready high; all per-command
// work is one combinational stage between those registers.
// When the receiver stalls, the result holds and one more command waits in
// the input register; s_tready drops only when both are full.
// Reset clears levels, smoothed values and duties to zero, selects red,
// sets min_level to 0 and smoothing_q8 to 26.
module rgb_led_dimmer_smooth_gamma_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // cmd[2:0], step[10:3], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // channel[1:0], red_duty[9:2], green_duty[17:10],
                                 // blue_duty[25:18], selected_level[33:26], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  logic       in_valid;
  logic [2:0] in_cmd;
  logic [7:0] in_step;
  logic       adv;

  logic [7:0] min_level;
  logic [8:0] smoothing_q8;
  logic [8:0] k_eff;

  logic [7:0] levels      [rgbd_pkg::NUM_CHAN];
  logic [7:0] levels_next [rgbd_pkg::NUM_CHAN];
  logic [1:0] sel;
  logic [1:0] sel_next;
  logic [7:0] duty        [rgbd_pkg::NUM_CHAN];
  logic       tick;

  logic [7:0]        lvl;
  logic [8:0]        inc_sum;
  logic [7:0]        inc_val;
  logic signed [9:0] dec_diff;
  logic [7:0]        dec_val;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;
  assign tick     = adv && (in_cmd == rgbd_pkg::CMD_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= s_tdata[2:0];
      in_step <= s_tdata[10:3];
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level    <= 8'd0;
      smoothing_q8 <= 9'd26;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rgbd_pkg::CFG_MIN_LEVEL: min_level    <= cfg_data[7:0];
        rgbd_pkg::CFG_SMOOTHING: smoothing_q8 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign k_eff = (smoothing_q8 > 9'(rgbd_pkg::K_MAX)) ? 9'(rgbd_pkg::K_MAX) : smoothing_q8;

  assign lvl      = levels[sel];
  assign inc_sum  = {1'b0, lvl} + {1'b0, in_step};
  assign inc_val  = (inc_sum > 9'(rgbd_pkg::MAX_LEVEL)) ? 8'(rgbd_pkg::MAX_LEVEL)
                                                        : inc_sum[7:0];
  assign dec_diff = $signed({2'b00, lvl}) - $signed({2'b00, in_step});
  assign dec_val  = (dec_diff < $signed({2'b00, min_level})) ? min_level : dec_diff[7:0];

  always_comb begin
    levels_next = levels;
    sel_next    = sel;
    unique case (in_cmd)
      rgbd_pkg::CMD_INC:  levels_next[sel] = inc_val;
      rgbd_pkg::CMD_DEC:  levels_next[sel] = dec_val;
      rgbd_pkg::CMD_NEXT: sel_next = (sel == rgbd_pkg::CHAN_BLUE) ? rgbd_pkg::CHAN_RED
                                                                  : sel + 2'd1;
      rgbd_pkg::CMD_PREV: sel_next = (sel == rgbd_pkg::CHAN_RED) ? rgbd_pkg::CHAN_BLUE
                                                                 : sel - 2'd1;
      rgbd_pkg::CMD_OFF: begin
        for (int c = 0; c < rgbd_pkg::NUM_CHAN; c++) levels_next[c] = 8'd0;
      end
      default: ;
    endcase
  end

  // state doubles as the result register: it only moves when the result slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < rgbd_pkg::NUM_CHAN; c++) levels[c] <= 8'd0;
      sel      <= rgbd_pkg::CHAN_RED;
      m_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        levels   <= levels_next;
        sel      <= sel_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  for (genvar c = 0; c < rgbd_pkg::NUM_CHAN; c++) begin : g_chan
    rgbd_chan u_chan (
      .clk    (clk),
      .rst    (rst),
      .tick   (tick),
      .k      (k_eff),
      .target (rgbd_pkg::SCALE_ROM[levels[c]]),
      .duty   (duty[c])
    );
  end

  assign m_tdata = {6'd0, levels[sel], duty[rgbd_pkg::CHAN_BLUE],
                    duty[rgbd_pkg::CHAN_GREEN], duty[rgbd_pkg::CHAN_RED], sel};

`ifndef SYNTHESIS
  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    sel != 2'd3)
    else $error("channel select out of range");

  a_duty_hold: assert property (@(posedge clk) disable iff (rst)
    !tick |=> $stable(duty[0]) && $stable(duty[1]) && $stable(duty[2]))
    else $error("duty changed without a tick");

  a_inc_cap: assert property (@(posedge clk) disable iff (rst)
    adv && in_cmd == rgbd_pkg::CMD_INC |=>
      levels[$past(sel)] <= 8'(rgbd_pkg::MAX_LEVEL))
    else $error("increase passed the maximum level");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !adv |=> in_valid && $stable(in_cmd) && $stable(in_step))
    else $error("pending command lost");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(sel) && $stable(levels[0]) && $stable(levels[1])
      && $stable(levels[2]))
    else $error("state moved while result slot held");
`endif

endmodule
